// ----- rtl/rrfp_pkg.sv -----
`timescale 1ns / 1ps

package rrfp_pkg;

    localparam int RRFP_MAX_PAYLOAD = 64;
    localparam int RRFP_MIN_PAYLOAD = 3;

    // header F4 F3 F2 F1: first three bytes as a window, then the last byte
    localparam logic [23:0] HDR_FIRST3 = 24'hF4F3F2;
    localparam logic [7:0]  HDR_LAST   = 8'hF1;

    typedef struct packed {
        logic        valid;
        logic        detected;
        logic [15:0] distance_cm;
        logic        presence_changed;
        logic        previous_detected;
    } rrfp_result_t;

    function automatic logic [7:0] footer_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF8;
            2'd1:    b = 8'hF7;
            2'd2:    b = 8'hF6;
            default: b = 8'hF5;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/rrfp_parser.sv -----
`timescale 1ns / 1ps

module rrfp_parser
    import rrfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = RRFP_MAX_PAYLOAD
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output rrfp_result_t result
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_FOOTER  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [23:0]      window_reg, window_next;
    logic [1:0]       fill_reg, fill_next;
    logic             len_step_reg, len_step_next;
    logic [7:0]       len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       presence_reg, presence_next;
    logic [15:0]      distance_reg, distance_next;
    logic [1:0]       footer_reg, footer_next;
    logic             last_det_reg, last_det_next;

    logic [7:0]       pos_inc;
    logic             det;

    assign pos_inc = 8'(pos_reg) + 8'd1;
    assign det     = (presence_reg != 8'd0);

    always_comb
    begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        fill_next     = fill_reg;
        len_step_next = len_step_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        presence_next = presence_reg;
        distance_next = distance_reg;
        footer_next   = footer_reg;
        last_det_next = last_det_reg;
        result        = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (fill_reg != 2'd3)
                begin
                    window_next = {window_reg[15:0], rx_byte};
                    fill_next   = fill_reg + 2'd1;
                end
                else if (window_reg == HDR_FIRST3 && rx_byte == HDR_LAST)
                begin
                    phase_next    = PH_LEN;
                    len_step_next = 1'b0;
                    fill_next     = 2'd0;
                end
                else
                begin
                    window_next = {window_reg[15:0], rx_byte};
                end
            end
            PH_LEN:
            begin
                if (!len_step_reg)
                begin
                    len_next      = rx_byte;
                    len_step_next = 1'b1;
                end
                else
                begin
                    len_step_next = 1'b0;
                    pos_next      = '0;
                    // nonzero high byte is always above the maximum
                    if (rx_byte != 8'd0 || len_reg < 8'(RRFP_MIN_PAYLOAD) ||
                        len_reg > 8'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_HUNT;
                        fill_next  = 2'd0;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (pos_reg == POS_W'(0))
                    presence_next = rx_byte;
                else if (pos_reg == POS_W'(1))
                    distance_next[7:0] = rx_byte;
                else if (pos_reg == POS_W'(2))
                    distance_next[15:8] = rx_byte;
                pos_next = POS_W'(pos_inc);
                if (pos_inc >= len_reg)
                begin
                    phase_next  = PH_FOOTER;
                    footer_next = 2'd0;
                end
            end
            default:
            begin
                if (rx_byte != footer_byte(footer_reg))
                begin
                    phase_next = PH_HUNT;
                    fill_next  = 2'd0;
                end
                else if (footer_reg != 2'd3)
                begin
                    footer_next = footer_reg + 2'd1;
                end
                else
                begin
                    result.valid             = step;
                    result.detected          = det;
                    result.distance_cm       = distance_reg;
                    result.presence_changed  = det ^ last_det_reg;
                    result.previous_detected = last_det_reg;
                    last_det_next            = det;
                    phase_next               = PH_HUNT;
                    fill_next                = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            window_reg   <= '0;
            fill_reg     <= '0;
            len_step_reg <= 1'b0;
            len_reg      <= '0;
            pos_reg      <= '0;
            presence_reg <= '0;
            distance_reg <= '0;
            footer_reg   <= '0;
            last_det_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            len_step_reg <= len_step_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            presence_reg <= presence_next;
            distance_reg <= distance_next;
            footer_reg   <= footer_next;
            last_det_reg <= last_det_next;
        end
    end

endmodule

// ----- rtl/radar_report_frame_parser_unit.sv -----
`timescale 1ns / 1ps

// channel   dir  width  fields (low bit first)
// s_axis    in   8      rx_byte[7:0]
// m_axis    out  24     detected, distance_cm[15:0], presence_changed,
//                       previous_detected, zero fill
//
// one byte per cycle unless a report sits unclaimed: an input register feeds
// the frame state update, whose report lands in an output register.
// a byte waits in the input register only while a report sits unclaimed.
// rst_n clears the parser to hunting with an empty window and no detection.

module radar_report_frame_parser_unit
    import rrfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = RRFP_MAX_PAYLOAD
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // detected, distance_cm, presence_changed,
                                        // previous_detected, 5'b0
);

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    logic         out_vld_reg;
    logic [18:0]  out_data_reg;
    logic         step;
    rrfp_result_t res;

    // parser advances whenever a byte is held and the output register can take a report
    assign step          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || step;

    rrfp_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .rx_byte(in_byte_reg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_vld_reg <= s_axis_tvalid;
            if (step)
                out_vld_reg <= res.valid;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
        if (step && res.valid)
            out_data_reg <= {res.previous_detected, res.presence_changed,
                             res.distance_cm, res.detected};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

    a_changed_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17] == (m_axis_tdata[0] ^ m_axis_tdata[18])))
        else $error("presence_changed disagrees with detected and previous_detected");

    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending report");

    a_no_report_without_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid && !in_vld_reg) |=> !m_axis_tvalid)
        else $error("report appeared without a byte");

endmodule
